### src/asdz_pkg.sv
// Shared types and constants for the analog stick dead-zone block.
`default_nettype none
package asdz_pkg;

  localparam int CfgIdxW = 8;
  localparam int AxisW   = 16;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TRIG_DZ   = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIG_FULL = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_STICK_DZ  = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_STICK_FULL = 8'd3;

  localparam logic [15:0] RST_TRIG_DZ    = 16'd250;
  localparam logic [15:0] RST_TRIG_FULL  = 16'd30000;
  localparam logic [15:0] RST_STICK_DZ   = 16'd8000;
  localparam logic [15:0] RST_STICK_FULL = 16'd30000;

  localparam logic [15:0] Q_ONE   = 16'h8000;
  localparam logic [15:0] OUT_MAX = 16'h7fff;

  // Pipeline layout: capture, squares, root, setup, fraction, multiply,
  // scaling division, output.
  localparam int RootSteps = 16;
  localparam int FracSteps = 15;
  localparam int DivSteps  = 16;
  localparam int StgSq     = 1;
  localparam int StgRoot0  = StgSq + 1;
  localparam int StgSetup  = StgRoot0 + RootSteps;
  localparam int StgFrac0  = StgSetup + 1;
  localparam int StgMul    = StgFrac0 + FracSteps;
  localparam int StgDiv0   = StgMul + 1;
  localparam int StgOut    = StgDiv0 + DivSteps;
  localparam int NumStg    = StgOut + 1;

  typedef struct packed {
    logic [15:0] trig_dz;
    logic [15:0] trig_full;
    logic [15:0] stick_dz;
    logic [15:0] stick_full;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic               sx;
    logic               sy;
    logic               zero;
    logic               full;
    logic [15:0]        ax;
    logic [15:0]        ay;
    logic [31:0]        s;
    logic [19:0]        rem;
    logic [15:0]        root;
    logic [15:0]        r;
    logic [15:0]        d;
    logic [15:0]        f;
    logic [31:0]        px;
    logic [31:0]        py;
    logic [16:0]        rx;
    logic [16:0]        ry;
    logic [15:0]        qx;
    logic [15:0]        qy;
    logic signed [15:0] ox;
    logic signed [15:0] oy;
  } pl_t;

endpackage
`default_nettype wire

### src/asdz_cfg.sv
// Configuration register file for the dead-zone block.
`default_nettype none
module asdz_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [asdz_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]                  cfg_data,
  output asdz_pkg::cfg_t                    cfg
);
  import asdz_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trig_dz    <= RST_TRIG_DZ;
      cfg.trig_full  <= RST_TRIG_FULL;
      cfg.stick_dz   <= RST_STICK_DZ;
      cfg.stick_full <= RST_STICK_FULL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TRIG_DZ:    cfg.trig_dz    <= cfg_data;
        REG_TRIG_FULL:  cfg.trig_full  <= cfg_data;
        REG_STICK_DZ:   cfg.stick_dz   <= cfg_data;
        REG_STICK_FULL: cfg.stick_full <= cfg_data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

endmodule
`default_nettype wire

### src/analog_stick_dead_zone.sv
// Top level: pipelined trigger / stick dead-zone conditioning.
`default_nettype none
// Conditions one controller sample per transaction. kind 0 is a trigger:
// |axis_x| beyond the trigger dead zone is rescaled so full scale reads
// 32767 (Q1.15, saturated), with the sign of axis_x; scaled_y is 0.
// kind 1 is a stick: the vector length floor(sqrt(x^2+y^2)) is taken, a
// radial dead zone applied, and both axes are scaled by f/len, truncated
// toward zero. The block takes a new sample every cycle unless every stage
// holds an item and the output is stalled. The pipeline holds the 16-stage
// square root, the 15-stage fraction divider and the 16-stage scaling
// dividers, one bit per stage. Each stage holds its item when the one ahead
// is full and stalled, so bubbles close up and the input stays ready while
// a result waits at the output, until every stage holds an item. Register
// writes take effect at once and belong between bursts of samples.
module analog_stick_dead_zone (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         kind,
  input  wire logic signed [15:0]           axis_x,
  input  wire logic signed [15:0]           axis_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [15:0]                scaled_x,
  output logic signed [15:0]                scaled_y,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [asdz_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [15:0]                  cfg_data
);
  import asdz_pkg::*;

  cfg_t cfg;

  asdz_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Work done on the way into stage k.
  function automatic pl_t link(input int k, input pl_t p, input cfg_t c);
    pl_t         n;
    logic [19:0] rsh;
    logic [19:0] trial;
    logic [16:0] r2;
    logic [16:0] dx;
    logic [16:0] dy;
    logic [15:0] m;
    logic [15:0] dz;
    logic [15:0] mx;
    logic [15:0] fs;
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [31:0] prx;
    logic [31:0] pry;
    int          j;
    n = p;
    if (k == StgSq) begin
      n.s    = ({16'd0, p.ax} * {16'd0, p.ax}) + ({16'd0, p.ay} * {16'd0, p.ay});
      n.rem  = '0;
      n.root = '0;
    end else if (k >= StgRoot0 && k < StgSetup) begin
      // one root digit per stage, pairs of bits from the top
      j     = StgSetup - 1 - k;
      rsh   = {p.rem[17:0], p.s[2*j+1 -: 2]};
      trial = {2'b00, p.root, 2'b01};
      if (rsh >= trial) begin
        n.rem  = rsh - trial;
        n.root = {p.root[14:0], 1'b1};
      end else begin
        n.rem  = rsh;
        n.root = {p.root[14:0], 1'b0};
      end
    end else if (k == StgSetup) begin
      if (p.kind) begin
        m      = p.root;
        dz     = c.stick_dz;
        mx     = c.stick_full;
        n.zero = (p.root == '0) || (p.root < c.stick_dz);
      end else begin
        m      = p.ax;
        dz     = c.trig_dz;
        mx     = c.trig_full;
        n.zero = (p.ax <= c.trig_dz);
        // trigger: scale 1 by f over 1, sign from axis_x
        n.ax   = 16'd1;
        n.ay   = '0;
        n.root = 16'd1;
      end
      n.r    = m - dz;
      n.d    = mx - dz;
      n.full = (mx <= dz) || ((m - dz) >= (mx - dz));
      n.f    = '0;
    end else if (k >= StgFrac0 && k < StgMul) begin
      // r < d here, so the quotient bits are a 15-bit fraction
      r2 = {p.r, 1'b0};
      if (r2 >= {1'b0, p.d}) begin
        n.r = 16'(r2 - {1'b0, p.d});
        n.f = {p.f[14:0], 1'b1};
      end else begin
        n.r = r2[15:0];
        n.f = {p.f[14:0], 1'b0};
      end
    end else if (k == StgMul) begin
      fs   = p.full ? Q_ONE : p.f;
      prx  = {16'd0, p.ax} * {16'd0, fs};
      pry  = {16'd0, p.ay} * {16'd0, fs};
      n.px = prx;
      n.py = pry;
      // quotient stays under 2^16, so the top half is already below len
      n.rx = {1'b0, prx[31:16]};
      n.ry = {1'b0, pry[31:16]};
      n.qx = '0;
      n.qy = '0;
    end else if (k >= StgDiv0 && k < StgOut) begin
      j  = StgOut - 1 - k;
      dx = {p.rx[15:0], p.px[j]};
      dy = {p.ry[15:0], p.py[j]};
      if (dx >= {1'b0, p.root}) begin
        n.rx = dx - {1'b0, p.root};
        n.qx = {p.qx[14:0], 1'b1};
      end else begin
        n.rx = dx;
        n.qx = {p.qx[14:0], 1'b0};
      end
      if (dy >= {1'b0, p.root}) begin
        n.ry = dy - {1'b0, p.root};
        n.qy = {p.qy[14:0], 1'b1};
      end else begin
        n.ry = dy;
        n.qy = {p.qy[14:0], 1'b0};
      end
    end else if (k == StgOut) begin
      mag_x = (p.qx > OUT_MAX) ? OUT_MAX : p.qx;
      mag_y = (p.qy > OUT_MAX) ? OUT_MAX : p.qy;
      if (p.zero) begin
        n.ox = '0;
        n.oy = '0;
      end else begin
        n.ox = p.sx ? signed'(16'(16'd0 - mag_x)) : signed'(mag_x);
        n.oy = p.sy ? signed'(16'(16'd0 - mag_y)) : signed'(mag_y);
      end
    end
    return n;
  endfunction

  logic [NumStg-1:0] vld;
  logic [NumStg-1:0] vin;
  logic [NumStg:0]   rdy;
  pl_t               stg [NumStg];
  pl_t               din [NumStg];
  pl_t               entry;

  // Capture: sign and magnitude of each axis.
  always_comb begin
    entry      = '0;
    entry.kind = kind;
    entry.sx   = axis_x[15];
    entry.sy   = axis_y[15];
    entry.ax   = axis_x[15] ? 16'(16'd0 - axis_x) : axis_x;
    entry.ay   = axis_y[15] ? 16'(16'd0 - axis_y) : axis_y;
  end

  assign rdy[NumStg] = out_ready;

  for (genvar k = 0; k < NumStg; k++) begin : g_stg
    if (k == 0) begin : g_head
      assign vin[k] = in_valid;
      assign din[k] = entry;
    end else begin : g_body
      assign vin[k] = vld[k-1];
      assign din[k] = stg[k-1];
    end

    // a stage may load when empty or when its item moves on
    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vin[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vin[k]) begin
        stg[k] <= link(k, din[k], cfg);
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld[NumStg-1];
  assign scaled_x  = stg[NumStg-1].ox;
  assign scaled_y  = stg[NumStg-1].oy;

endmodule
`default_nettype wire

### src/asdz_chk.sv
// Port-level checker for the dead-zone block, bound to the top level.
`default_nettype none
module asdz_chk (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic signed [15:0]           scaled_x,
  input wire logic signed [15:0]           scaled_y
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scaled_x) && $stable(scaled_y))
    else $error("result changed while stalled");

  // saturation keeps the most negative code out
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> scaled_x != -16'sd32768 && scaled_y != -16'sd32768)
    else $error("result not saturated");

  // pipeline flushes on reset
  a_rst: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a draining output never blocks the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

endmodule

bind analog_stick_dead_zone asdz_chk u_asdz_chk (.*);
`default_nettype wire
